// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside of reset
`define SIL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sil assertion failed");

// property checked on every clock edge, reset included
`define SIL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sil assertion failed");

`else

`define SIL_ASSERT(lbl, clk, rst_n, prop)
`define SIL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/sil_pkg.sv =====
// package with types and constants of the sorted intercept list
`timescale 1ns / 1ps

package sil_pkg;

  // default sizes
  localparam int CAPACITY = 32;
  localparam int TAG_BITS = 16;

  // distance as stored: unsigned q1.16 in zero to one
  localparam int DIST_W = 17;
  localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_POP   = 2'd2,
    CMD_NONE  = 2'd3
  } sil_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } sil_status_e;

  // control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_PUT,
    S_POP_READ,
    S_RESP
  } sil_state_e;

endpackage

// ===== src/sil_store.sv =====
// entry memory: one write port and one registered read port
`timescale 1ns / 1ps

module sil_store #(
  parameter int DEPTH = sil_pkg::CAPACITY,
  parameter int WIDTH = 1 + sil_pkg::TAG_BITS + sil_pkg::DIST_W
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sorted_intercept_list_top.sv =====
// top level of the sorted intercept list with its control sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sorted intercept list. Keeps up to CAPACITY entries (kind, tag, distance)
// in ascending distance order in one single-port-read, single-port-write
// memory. One command word is taken at a time; every command gives exactly
// one result word. Clear, the unused command and rejected adds go straight
// to the response state. A pop reads the memory in S_POP_READ first. An add
// with no unread entry in the list writes the tail at once and goes to the
// response state. Any other accepted add reads the tail and walks down,
// moving one larger entry up per cycle, and writes the new entry into the
// freed slot before it answers. The next command is taken in the cycle after
// its result moves into the output register. The result register lets a new
// command be taken while the previous result still waits on the output.
// Memory contents are not cleared; only entries below the fill count are
// ever read.

module sorted_intercept_list_top #(
  parameter int CAPACITY = sil_pkg::CAPACITY,
  parameter int TAG_BITS = sil_pkg::TAG_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command side
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       cmd_i,
  input  logic                             kind_i,
  input  logic [TAG_BITS-1:0]              object_tag_i,
  input  logic signed [31:0]               distance_i,
  // result side
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic                             out_kind_o,
  output logic [TAG_BITS-1:0]              out_tag_o,
  output logic [sil_pkg::DIST_W-1:0]       out_distance_o,
  output logic                             last_o,
  output logic [$clog2(CAPACITY+1)-1:0]    fill_o
);

  localparam int DW = sil_pkg::DIST_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 1 + TAG_BITS + DW;

  sil_pkg::sil_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rdpos_q, rdpos_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [EW-1:0] new_q, new_d;

  logic [1:0]          res_status_q, res_status_d;
  logic                res_kind_q, res_kind_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  logic [DW-1:0]       res_dist_q, res_dist_d;
  logic                res_last_q, res_last_d;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q;
  logic                out_kind_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [DW-1:0]       out_dist_q;
  logic                out_last_q;
  logic [CW-1:0]       out_fill_q;
  logic                out_load;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [CW-1:0] cnt_m1, pos_m1, pos_m2, rdpos_p1;
  logic          in_dist_ok;
  logic [EW-1:0] in_entry;
  logic [DW-1:0] rd_dist, new_dist;

  // entry memory
  sil_store #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // helpers
  assign cnt_m1   = count_q - CW'(1);
  assign pos_m1   = pos_q - CW'(1);
  assign pos_m2   = pos_q - CW'(2);
  assign rdpos_p1 = rdpos_q + CW'(1);

  assign in_dist_ok = !distance_i[31] && (distance_i[30:0] <= 31'(sil_pkg::ONE_Q16));
  assign in_entry   = {kind_i, object_tag_i, distance_i[DW-1:0]};
  assign rd_dist    = rd_data[DW-1:0];
  assign new_dist   = new_q[DW-1:0];

  assign in_stall_o = (state_q != sil_pkg::S_IDLE);

  // sequencer: next state, memory access and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rdpos_d      = rdpos_q;
    pos_d        = pos_q;
    new_d        = new_q;
    res_status_d = res_status_q;
    res_kind_d   = res_kind_q;
    res_tag_d    = res_tag_q;
    res_dist_d   = res_dist_q;
    res_last_d   = res_last_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_q[AW-1:0];
    wr_data      = new_q;
    out_load     = 1'b0;

    case (state_q)
      sil_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = sil_pkg::ST_OK;
          res_kind_d   = 1'b0;
          res_tag_d    = '0;
          res_dist_d   = '0;
          res_last_d   = 1'b0;
          state_d      = sil_pkg::S_RESP;
          case (sil_pkg::sil_cmd_e'(cmd_i))
            sil_pkg::CMD_CLEAR: begin
              count_d = '0;
              rdpos_d = '0;
            end
            sil_pkg::CMD_ADD: begin
              if (!in_dist_ok) begin
                res_status_d = sil_pkg::ST_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                res_status_d = sil_pkg::ST_FULL;
              end else begin
                new_d = in_entry;
                pos_d = count_q;
                if (count_q > rdpos_q) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_m1[AW-1:0];
                  state_d = sil_pkg::S_ADD_SCAN;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = count_q[AW-1:0];
                  wr_data = in_entry;
                  count_d = count_q + CW'(1);
                end
              end
            end
            sil_pkg::CMD_POP: begin
              if (rdpos_q >= count_q) begin
                res_status_d = sil_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = rdpos_q[AW-1:0];
                state_d = sil_pkg::S_POP_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // move larger entries up by one until the slot is found
      sil_pkg::S_ADD_SCAN: begin
        if (rd_dist > new_dist) begin
          wr_en   = 1'b1;
          wr_addr = pos_q[AW-1:0];
          wr_data = rd_data;
          pos_d   = pos_m1;
          if (pos_m1 > rdpos_q) begin
            rd_en   = 1'b1;
            rd_addr = pos_m2[AW-1:0];
          end else begin
            state_d = sil_pkg::S_ADD_PUT;
          end
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          state_d = sil_pkg::S_RESP;
        end
      end

      // new entry goes into the freed slot
      sil_pkg::S_ADD_PUT: begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
        state_d = sil_pkg::S_RESP;
      end

      sil_pkg::S_POP_READ: begin
        res_kind_d = rd_data[EW-1];
        res_tag_d  = rd_data[EW-2:DW];
        res_dist_d = rd_dist;
        res_last_d = (rdpos_p1 == count_q);
        rdpos_d    = rdpos_p1;
        state_d    = sil_pkg::S_RESP;
      end

      // hand the result to the output register once it is free
      sil_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = sil_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sil_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sil_pkg::S_IDLE;
      count_q     <= '0;
      rdpos_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rdpos_q     <= rdpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    new_q        <= new_d;
    res_status_q <= res_status_d;
    res_kind_q   <= res_kind_d;
    res_tag_q    <= res_tag_d;
    res_dist_q   <= res_dist_d;
    res_last_q   <= res_last_d;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_kind_q   <= res_kind_q;
      out_tag_q    <= res_tag_q;
      out_dist_q   <= res_dist_q;
      out_last_q   <= res_last_q;
      out_fill_q   <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_kind_o     = out_kind_q;
  assign out_tag_o      = out_tag_q;
  assign out_distance_o = out_dist_q;
  assign last_o         = out_last_q;
  assign fill_o         = out_fill_q;

  // checks
  `SIL_ASSERT(a_rdpos_le_count, clk_i, rst_ni, rdpos_q <= count_q)
  `SIL_ASSERT(a_count_le_cap, clk_i, rst_ni, count_q <= CW'(CAPACITY))
  `SIL_ASSERT(a_scan_above_rdpos, clk_i, rst_ni, (state_q == sil_pkg::S_ADD_SCAN) |-> (pos_q > rdpos_q))
  `SIL_ASSERT(a_out_from_resp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == sil_pkg::S_RESP))

endmodule
